### design/fbpp_pkg.sv
package fbpp_pkg;

    localparam int CMD_W      = 2;
    localparam int COORD_W    = 9;
    localparam int COLOR_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 24;

    localparam logic [CMD_W-1:0] CMD_SET   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_GET   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BYTE_PIXELS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_FIRST      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_OPAQUE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_FIRST       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PLANAR_LAYOUT    = 3'd6;

    localparam logic [CFG_DATA_W-1:0] FRAME_SIZE_RESET = 10'd512;
    localparam logic [COLOR_W-1:0]    ALPHA_OPAQUE_VAL = 8'd255;

endpackage

### design/framebuffer_pixel_port_core.sv
// Pixel port onto a byte-addressed frame store of MAX_WIDTH*MAX_HEIGHT*4 bytes.
// Commands arrive on the slave stream (tuser = command, tdata = position and
// color); every command gives exactly one transfer on the master stream
// (tdata = color read by a get, tuser = coordinate error flag).
// The user must write the pixel format registers through the cfg channel only while
// idle; the block does not enforce this. The store is one byte-wide synchronous memory
// with one access per cycle, so a command is processed one byte at a time:
//   set: writes the three color bytes of the pixel
//   get: reads the three color bytes of the pixel
//   out-of-frame set/get, unused command: goes straight to the result
//   clear: writes all w*h*3 (or w*h*4 with four-byte pixels) bytes of the frame
// Only one command is in flight; s_tready is high only while idle.
// A finished result sits in the output register; if the receiver stalls,
// the block takes the next command and finishes it, then holds it until the
// output register frees up.
// Reset restores the format registers (512x512, three-byte packed RGB) and
// empties the output register; the store itself is not touched by reset and
// holds nothing defined until cleared or written.
module framebuffer_pixel_port_core
    import fbpp_pkg::*;
#(
    parameter int MAX_WIDTH  = 512,
    parameter int MAX_HEIGHT = 512
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // cfg write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // command stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // pos_x, pos_y, red_in, green_in, blue_in, zeros
    input  logic [CMD_W-1:0]      i_s_tuser,   // command
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata,   // red_out, green_out, blue_out
    output logic [0:0]            o_m_tuser    // coord_error
);

    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT * 4;
    localparam int AW          = $clog2(STORE_DEPTH);
    localparam int CNTW        = AW + 1;
    localparam int WW          = $clog2(MAX_WIDTH + 1);
    localparam int HW          = $clog2(MAX_HEIGHT + 1);
    localparam int PLW         = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_ADDR,
        S_ACC,
        S_LAST,
        S_CLR,
        S_DONE
    } t_state;

    t_state r_state;

    // format registers
    logic [CFG_DATA_W-1:0] r_frame_width;
    logic [CFG_DATA_W-1:0] r_frame_height;
    logic                  r_four;
    logic                  r_alpha_first;
    logic                  r_alpha_opaque;
    logic                  r_blue_first;
    logic                  r_planar;

    // command in flight
    logic [CMD_W-1:0]   r_cmd;
    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [COLOR_W-1:0] r_red;
    logic [COLOR_W-1:0] r_green;
    logic [COLOR_W-1:0] r_blue;
    logic               r_inside;
    logic [PLW-1:0]     r_plane;
    logic [PLW-1:0]     r_row;
    logic [AW-1:0]      r_addr;
    logic [AW-1:0]      r_step;
    logic [1:0]         r_idx;
    logic [CNTW-1:0]    r_cnt;
    logic [CNTW-1:0]    r_total;
    logic [CNTW-1:0]    r_lo;
    logic [CNTW-1:0]    r_hi;
    logic [COLOR_W-1:0] r_c0;
    logic [COLOR_W-1:0] r_c1;
    logic [COLOR_W-1:0] r_c2;

    // output register
    logic                 r_m_valid;
    logic [M_TDATA_W-1:0] r_m_data;
    logic                 r_m_err;

    // store
    logic [COLOR_W-1:0] r_store [STORE_DEPTH];
    logic [COLOR_W-1:0] r_rd_data;

    logic [WW-1:0]      w_eff_w;
    logic [HW-1:0]      w_eff_h;
    logic               w_pix_cmd;
    logic               w_alpha_lead;
    logic [AW-1:0]      w_pix;
    logic [AW-1:0]      w_plane_a;
    logic [AW-1:0]      w_base;
    logic [CNTW-1:0]    w_plane_c;
    logic [CNTW-1:0]    w_plane3;
    logic [CNTW-1:0]    n_cnt;
    logic               w_clr_alpha;
    logic               w_mem_we;
    logic [AW-1:0]      w_mem_addr;
    logic [COLOR_W-1:0] w_mem_wd;
    logic [COLOR_W-1:0] w_set_byte;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;
    assign o_m_tuser   = r_m_err;

    // widths and heights above the maximum act as the maximum
    always_comb begin
        w_eff_w = (32'(r_frame_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(r_frame_width);
        w_eff_h = (32'(r_frame_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(r_frame_height);
    end

    always_comb begin
        w_pix_cmd    = (r_cmd == CMD_SET) || (r_cmd == CMD_GET);
        w_alpha_lead = r_four && r_alpha_first;
        w_pix        = AW'(r_x) + AW'(r_row);
        w_plane_a    = AW'(r_plane);
        w_plane_c    = CNTW'(r_plane);
        w_plane3     = (w_plane_c << 1) + w_plane_c;
        if (r_planar) begin
            w_base = w_pix + (w_alpha_lead ? w_plane_a : '0);
        end else if (r_four) begin
            w_base = (w_pix << 2) + AW'(w_alpha_lead);
        end else begin
            w_base = (w_pix << 1) + w_pix;
        end
        n_cnt = r_cnt + 1'b1;
    end

    // alpha bytes of a clear get the opaque value when alpha_opaque is set; all other bytes get zero
    always_comb begin
        if (!(r_four && r_alpha_opaque)) begin
            w_clr_alpha = 1'b0;
        end else if (r_planar) begin
            w_clr_alpha = (r_cnt >= r_lo) && (r_cnt < r_hi);
        end else begin
            w_clr_alpha = (r_cnt[1:0] == (r_alpha_first ? 2'd0 : 2'd3));
        end
    end

    always_comb begin
        case (r_idx)
            2'd0:    w_set_byte = r_blue_first ? r_blue : r_red;
            2'd1:    w_set_byte = r_green;
            default: w_set_byte = r_blue_first ? r_red : r_blue;
        endcase
        w_mem_we   = ((r_state == S_ACC) && (r_cmd == CMD_SET)) || (r_state == S_CLR);
        w_mem_addr = (r_state == S_CLR) ? r_cnt[AW-1:0] : r_addr;
        if (r_state == S_CLR) begin
            w_mem_wd = w_clr_alpha ? ALPHA_OPAQUE_VAL : '0;
        end else begin
            w_mem_wd = w_set_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_store[w_mem_addr] <= w_mem_wd;
        end
        r_rd_data <= r_store[w_mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_m_valid      <= 1'b0;
            r_frame_width  <= FRAME_SIZE_RESET;
            r_frame_height <= FRAME_SIZE_RESET;
            r_four         <= 1'b0;
            r_alpha_first  <= 1'b0;
            r_alpha_opaque <= 1'b0;
            r_blue_first   <= 1'b0;
            r_planar       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_FRAME_WIDTH:      r_frame_width  <= i_cfg_data;
                    CFG_FRAME_HEIGHT:     r_frame_height <= i_cfg_data;
                    CFG_FOUR_BYTE_PIXELS: r_four         <= i_cfg_data[0];
                    CFG_ALPHA_FIRST:      r_alpha_first  <= i_cfg_data[0];
                    CFG_ALPHA_OPAQUE:     r_alpha_opaque <= i_cfg_data[0];
                    CFG_BLUE_FIRST:       r_blue_first   <= i_cfg_data[0];
                    CFG_PLANAR_LAYOUT:    r_planar       <= i_cfg_data[0];
                    default: ;
                endcase
            end

            // in S_DONE the output register is reloaded below instead
            if (r_m_valid && i_m_tready && (r_state != S_DONE)) begin
                r_m_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_cmd   <= i_s_tuser;
                        r_x     <= i_s_tdata[8:0];
                        r_y     <= i_s_tdata[17:9];
                        r_red   <= i_s_tdata[25:18];
                        r_green <= i_s_tdata[33:26];
                        r_blue  <= i_s_tdata[41:34];
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_inside <= (32'(r_x) < 32'(w_eff_w)) && (32'(r_y) < 32'(w_eff_h));
                    r_plane  <= PLW'(w_eff_w) * PLW'(w_eff_h);
                    r_row    <= PLW'(r_y) * PLW'(w_eff_w);
                    r_state  <= S_ADDR;
                end
                S_ADDR: begin
                    r_addr  <= w_base;
                    r_step  <= r_planar ? w_plane_a : AW'(1);
                    r_idx   <= 2'd0;
                    r_cnt   <= '0;
                    r_total <= r_four ? (w_plane_c << 2) : w_plane3;
                    r_lo    <= r_alpha_first ? '0 : w_plane3;
                    r_hi    <= r_alpha_first ? w_plane_c : (w_plane_c << 2);
                    if (w_pix_cmd && r_inside) begin
                        r_state <= S_ACC;
                    end else if ((r_cmd == CMD_CLEAR) && (r_plane != '0)) begin
                        r_state <= S_CLR;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_ACC: begin
                    r_addr <= r_addr + r_step;
                    r_idx  <= r_idx + 1'b1;
                    // read data is registered, so it lags the address
                    if (r_idx == 2'd1) begin
                        r_c0 <= r_rd_data;
                    end
                    if (r_idx == 2'd2) begin
                        r_c1    <= r_rd_data;
                        r_state <= (r_cmd == CMD_GET) ? S_LAST : S_DONE;
                    end
                end
                S_LAST: begin
                    r_c2    <= r_rd_data;
                    r_state <= S_DONE;
                end
                S_CLR: begin
                    r_cnt <= n_cnt;
                    if (n_cnt == r_total) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_valid <= 1'b1;
                        r_m_err   <= w_pix_cmd && !r_inside;
                        if ((r_cmd == CMD_GET) && r_inside) begin
                            r_m_data <= r_blue_first ? {r_c0, r_c1, r_c2} : {r_c2, r_c1, r_c0};
                        end else begin
                            r_m_data <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_err_no_color: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata == '0))
        else $error("coordinate error carries nonzero color");

    a_clear_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> (r_cnt < r_total))
        else $error("clear sweep ran past the frame");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("second command taken while one is in flight");

    a_get_reads_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_ACC) && (r_cmd == CMD_GET)) |-> !w_mem_we)
        else $error("store written during a get");

endmodule
